>>> hw/rtl/dali_forward_frame_transmitter_top_macros.svh
// Assertion macros for the DALI forward frame transmitter.
`ifndef DALI_FORWARD_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define DALI_FORWARD_FRAME_TRANSMITTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DALI_ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DALI_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> hw/rtl/dali_fft_pkg.sv
// Shared types and constants of the DALI forward frame transmitter.
package dali_fft_pkg;

   localparam int unsigned FrameLen   = 17;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned StopWidth  = 3;

   localparam logic [CountWidth-1:0] FrameLenCount = CountWidth'(FrameLen);
   localparam logic [StopWidth-1:0]  StopLast      = StopWidth'(4);

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_BITS = 3'b010,
      PHASE_STOP = 3'b100
   } phase_type;

   typedef struct packed {
      logic load_refused;
      logic frame_done;
      logic busy_res;
      logic line_level;
   } result_type;

endpackage

>>> hw/rtl/dali_fft_engine.sv
// Frame sequencer: Manchester bit phase, stop ticks and line level.
module dali_fft_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    cmd,
   input  logic [7:0]              frame_address,
   input  logic [7:0]              frame_data,
   output dali_fft_pkg::result_type result
);
   import dali_fft_pkg::*;

   logic [FrameLen-1:0]   frame_bits_ff, frame_bits_in;
   logic [CountWidth-1:0] bits_left_ff, bits_left_in;
   logic                  second_half_ff, second_half_in;
   logic [StopWidth-1:0]  stop_count_ff, stop_count_in;
   phase_type             phase_ff, phase_in;
   logic                  line_ff, line_in;
   logic                  done;
   logic                  refused;
   logic                  cur_bit;

   assign cur_bit = frame_bits_ff[FrameLen-1];

   always_comb begin
      frame_bits_in  = frame_bits_ff;
      bits_left_in   = bits_left_ff;
      second_half_in = second_half_ff;
      stop_count_in  = stop_count_ff;
      phase_in       = phase_ff;
      line_in        = line_ff;
      done           = 1'b0;
      refused        = 1'b0;
      if (cmd) begin
         if (phase_ff != PHASE_IDLE) begin
            refused = 1'b1;
         end else begin
            frame_bits_in  = {1'b1, frame_address, frame_data};
            bits_left_in   = FrameLenCount;
            second_half_in = 1'b0;
            stop_count_in  = '0;
            phase_in       = PHASE_BITS;
         end
      end else begin
         unique case (phase_ff)
            PHASE_BITS: begin
               if (bits_left_ff == '0) begin
                  phase_in      = PHASE_STOP;
                  stop_count_in = '0;
                  line_in       = 1'b1;
               end else if (!second_half_ff) begin
                  // first half carries the inverted bit
                  line_in        = ~cur_bit;
                  second_half_in = 1'b1;
               end else begin
                  line_in        = cur_bit;
                  second_half_in = 1'b0;
                  frame_bits_in  = {frame_bits_ff[FrameLen-2:0], 1'b0};
                  bits_left_in   = bits_left_ff - CountWidth'(1);
                  if (bits_left_ff == CountWidth'(1)) begin
                     phase_in      = PHASE_STOP;
                     stop_count_in = '0;
                  end
               end
            end
            PHASE_STOP: begin
               line_in = 1'b1;
               if (stop_count_ff < StopLast) begin
                  stop_count_in = stop_count_ff + StopWidth'(1);
               end else begin
                  stop_count_in = '0;
                  phase_in      = PHASE_IDLE;
                  done          = 1'b1;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
               line_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff  <= '0;
         bits_left_ff   <= '0;
         second_half_ff <= 1'b0;
         stop_count_ff  <= '0;
         phase_ff       <= PHASE_IDLE;
         line_ff        <= 1'b1;
      end else if (step) begin
         frame_bits_ff  <= frame_bits_in;
         bits_left_ff   <= bits_left_in;
         second_half_ff <= second_half_in;
         stop_count_ff  <= stop_count_in;
         phase_ff       <= phase_in;
         line_ff        <= line_in;
      end
   end

   assign result.line_level   = line_in;
   assign result.busy_res     = (phase_in != PHASE_IDLE);
   assign result.frame_done   = done;
   assign result.load_refused = refused;

endmodule

>>> hw/rtl/dali_forward_frame_transmitter_top.sv
// DALI forward frame transmitter top level: stream ports and result register.
//
// Every request on the req_ channel is one half-bit tick (req_tuser = 0) or a
// frame load (req_tuser = 1, address and data in req_tdata), and yields exactly
// one response holding the bus level and status after it. A load while idle
// latches start bit, address and data (MSB first); each bit then takes two
// ticks (one = low then high, zero = high then low), followed by five high
// stop ticks, the last flagged by frame_done. A load while busy is dropped and
// flagged by load_refused. The sequencer state and the response register
// update on the accept edge, and req_tready stays high as long as the response
// register is empty or being drained, so one request per cycle flows. The line
// idles high after reset.
`include "dali_forward_frame_transmitter_top_macros.svh"

module dali_forward_frame_transmitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] frame_address, [15:8] frame_data
   input  logic        req_tuser,   // [0] cmd: 0 = tick, 1 = load
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] line_level, [1] busy_res,
                                    // [2] frame_done, [3] load_refused, [7:4] 0
);
   import dali_fft_pkg::*;

   logic       req_accept;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // response register frees itself when drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   dali_fft_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (req_accept),
      .cmd           (req_tuser),
      .frame_address (req_tdata[7:0]),
      .frame_data    (req_tdata[15:8]),
      .result        (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   `DALI_ASSERT_IMPLIES(a_done_ends_busy, clock, reset,
      rsp_tvalid && rsp_tdata[2], !rsp_tdata[1], "frame_done with busy still set")
   `DALI_ASSERT_IMPLIES(a_refused_when_busy, clock, reset,
      rsp_tvalid && rsp_tdata[3], rsp_tdata[1], "load refused while idle")
   `DALI_ASSERT_IMPLIES(a_idle_line_high, clock, reset,
      rsp_tvalid && !rsp_tdata[1], rsp_tdata[0], "line low while idle")
   `DALI_ASSERT_NEXT(a_accept_sets_valid, clock, reset,
      req_accept, rsp_valid_ff, "accepted request produced no response")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the DALI forward frame transmitter: tick/load stream against a predictor.
module tb;
   import dali_fft_pkg::*;

   // Request kinds carried on req_tuser.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Start bit plus two data bytes, two half-bit ticks each, then five stop ticks.
   localparam int FRAME_TICKS  = 2 * FrameLen + 5;
   localparam int RANDOM_ITEMS = 1700;
   localparam int LONG_HOLD    = 90;    // receiver hold-off, long enough to back up the block
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up

   // Predicts the line level and status after each request and checks responses in order.
   class line_status_scoreboard;
      phase_type             phase       = PHASE_IDLE;
      logic [FrameLen-1:0]   frame_bits  = '0;
      logic [CountWidth-1:0] bits_left   = '0;
      logic                  second_half = 1'b0;
      logic [StopWidth-1:0]  stop_count  = '0;
      logic                  line_reg    = 1'b1;
      result_type            expected_status[$];
      int unsigned           errors      = 0;
      int unsigned           responses   = 0;

      function void note_request(logic cmd, logic [7:0] address, logic [7:0] data);
         result_type status;
         status = '0;
         if (cmd == CMD_LOAD) begin
            if (phase != PHASE_IDLE) begin
               status.load_refused = 1'b1;
            end else begin
               // line keeps its level until the first tick
               frame_bits  = {1'b1, address, data};
               bits_left   = FrameLenCount;
               second_half = 1'b0;
               stop_count  = '0;
               phase       = PHASE_BITS;
            end
         end else begin
            case (phase)
               PHASE_BITS: begin
                  if (bits_left == 0) begin
                     phase      = PHASE_STOP;
                     stop_count = '0;
                     line_reg   = 1'b1;
                  end else if (!second_half) begin
                     line_reg    = ~frame_bits[FrameLen-1];
                     second_half = 1'b1;
                  end else begin
                     line_reg    = frame_bits[FrameLen-1];
                     second_half = 1'b0;
                     frame_bits  = frame_bits << 1;
                     bits_left   = bits_left - 1'b1;
                     if (bits_left == 0) begin
                        phase      = PHASE_STOP;
                        stop_count = '0;
                     end
                  end
               end
               PHASE_STOP: begin
                  line_reg = 1'b1;
                  if (stop_count < StopLast) begin
                     stop_count = stop_count + 1'b1;
                  end else begin
                     stop_count        = '0;
                     phase             = PHASE_IDLE;
                     status.frame_done = 1'b1;
                  end
               end
               default: begin
                  line_reg = 1'b1;
               end
            endcase
         end
         status.line_level = line_reg;
         status.busy_res   = (phase != PHASE_IDLE);
         expected_status.push_back(status);
      endfunction

      task report_mismatch(string field, int got, int want);
         errors++;
         $display("%0t: response %0d: %s is %0d, expected %0d", $time, responses, field, got,
                  want);
      endtask

      task check_status(logic [7:0] tdata);
         result_type want;
         result_type got;
         responses++;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response, data", tdata, 0);
            return;
         end
         want = expected_status.pop_front();
         got  = tdata[3:0];
         if (got.line_level !== want.line_level)
            report_mismatch("line_level", got.line_level, want.line_level);
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
         if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
         if (got.load_refused !== want.load_refused)
            report_mismatch("load_refused", got.load_refused, want.load_refused);
         if (tdata[7:4] !== 4'h0)
            report_mismatch("padding", tdata[7:4], 0);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   line_status_scoreboard sb;

   int frame_ticks_left = 0;  // sender's own guess of ticks until the frame ends
   bit calm             = 1'b0;  // both sides run without idling while set
   bit hold_request     = 1'b0;  // asks the receiver for one long hold-off

   dali_forward_frame_transmitter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Mostly random bytes, with the all-zero and all-one values now and then.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one request after a random gap; returns at the falling edge after it is taken.
   task automatic send_request(logic cmd, logic [7:0] address, logic [7:0] data);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {data, address};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cmd == CMD_LOAD) begin
         if (frame_ticks_left == 0) frame_ticks_left = FRAME_TICKS;
      end else if (frame_ticks_left > 0) begin
         frame_ticks_left--;
      end
   endtask

   // Stimulus: a short directed frame, then random frames with stray loads.
   initial begin
      logic cmd;
      sb         = new;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_TICK;
      req_tdata  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_request(CMD_TICK, 8'h00, 8'h00);   // tick while idle: line stays high
      send_request(CMD_LOAD, 8'hFF, 8'h00);   // address all ones, data all zeros
      send_request(CMD_LOAD, 8'h00, 8'hFF);   // load while busy, refused
      repeat (18) send_request(CMD_TICK, pick_byte(), pick_byte());  // ticks ignore tdata
      send_request(CMD_LOAD, 8'hFF, 8'hFF);   // refused at a bit boundary

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         if (i == 400) begin
            // back-to-back requests against a stalled receiver
            calm         = 1'b1;
            hold_request = 1'b1;
         end
         if (i == 800) begin
            // let every outstanding response drain before going on
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (sb.expected_status.size() != 0) @(negedge clock);
         end
         if (frame_ticks_left == 0)
            cmd = ($urandom_range(0, 4) != 0) ? CMD_LOAD : CMD_TICK;
         else
            cmd = ($urandom_range(0, 24) == 0) ? CMD_LOAD : CMD_TICK;
         send_request(cmd, pick_byte(), pick_byte());
      end
      req_tvalid <= 1'b0;

      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);  // catch any stray response
      if (sb.errors == 0)
         $display("** dali_forward_frame_transmitter_top: PASSED **");
      else
         $display("** dali_forward_frame_transmitter_top: FAILED **");
      $finish;
   end

   // Receiver: random hold-offs before each response, one long one on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 14);
         if (hold_request) begin
            gap          = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && !reset));
         @(negedge clock);
      end
   end

   // Handshake monitor: requests feed the predictor, responses are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready)
            sb.check_status(rsp_tdata);
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("** dali_forward_frame_transmitter_top: FAILED **");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dali_fft_pkg.sv
hw/rtl/dali_fft_engine.sv
hw/rtl/dali_forward_frame_transmitter_top.sv
dv/tb.sv
